/* hdl/wsd_pkg.sv */
// ----------------------------------------------------------------------------
// wsd_pkg: shared types and constants of the windowed stability detector
// Register indexes, field widths, sequencer states and the command struct of
// the shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
package wsd_pkg;

	// stream payload layout
	localparam int IN_DATA_W      = 64;
	localparam int SAMPLE_FIELD_W = 32;
	localparam int OUT_DATA_W     = 16;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int TOL_W      = 32;
	localparam int REQ_W      = 8;
	localparam int WLEN_W     = 10;

	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REQUIRED  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 2'd2;

	localparam logic [TOL_W-1:0]  TOL_RESET  = 32'd4295;
	localparam logic [REQ_W-1:0]  REQ_RESET  = 8'd3;
	localparam logic [WLEN_W-1:0] WLEN_RESET = 10'd500;

	// request kinds carried in tuser
	localparam logic ACTION_ADD   = 1'b0;
	localparam logic ACTION_CHECK = 1'b1;

	localparam logic [REQ_W-1:0] STREAK_MAX = 8'd255;

	// multiply-accumulate unit: 32x32 partial products into a wide accumulator
	localparam int LIMB_W    = 32;
	localparam int MAC_A_W   = 3 * LIMB_W;
	localparam int MAC_B_W   = 2 * LIMB_W;
	localparam int MAC_ACC_W = MAC_A_W + MAC_B_W;

	typedef struct packed {
		logic       start;
		logic [1:0] a_last;   // index of the top limb of operand a
		logic       b_last;   // index of the top limb of operand b
	} mac_cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ_LN,     // square of new lift sample
		ST_SQ_LO,     // square of evicted lift sample
		ST_SQ_DN,
		ST_SQ_DO,
		ST_ADD_UPD,
		ST_T2,        // tolerance squared
		ST_SIG,       // pick path for current signal
		ST_S2,        // sum squared
		ST_NQ,        // n * square sum, then D
		ST_TS,        // T^2 * S^2 and compare
		ST_TN,        // T^2 * n and compare (zero mean)
		ST_STREAK,
		ST_FINISH
	} wsd_state_t;

endpackage

/* hdl/wsd_mac.sv */
// ----------------------------------------------------------------------------
// wsd_mac: shared iterative multiplier
// Multiplies a (up to three 32-bit limbs) by b (up to two limbs), one 32x32
// partial product per cycle, summed into a wide accumulator. done pulses
// for one cycle when prod holds the full product.
// ----------------------------------------------------------------------------
module wsd_mac (
	input  logic                          clk,
	input  logic                          arst_n,
	input  wsd_pkg::mac_cmd_t             cmd,
	input  logic [wsd_pkg::MAC_A_W-1:0]   a,
	input  logic [wsd_pkg::MAC_B_W-1:0]   b,
	output logic                          done,
	output logic [wsd_pkg::MAC_ACC_W-1:0] prod
);
	import wsd_pkg::*;

	logic [MAC_A_W-1:0]   a_q;
	logic [MAC_B_W-1:0]   b_q;
	logic [1:0]           a_last_q;
	logic                 b_last_q;
	logic [1:0]           i_q;
	logic                 j_q;
	logic                 run_q;
	logic                 vld_s1;
	logic                 last_s1;
	logic [2*LIMB_W-1:0]  prod_s1;
	logic [1:0]           sh_s1;
	logic [MAC_ACC_W-1:0] acc_q;
	logic                 done_q;

	logic                 issue_last;
	logic [LIMB_W-1:0]    a_limb;
	logic [LIMB_W-1:0]    b_limb;
	logic [MAC_ACC_W-1:0] partial;

	assign issue_last = (i_q == a_last_q) && (j_q == b_last_q);
	assign a_limb     = a_q[i_q*LIMB_W +: LIMB_W];
	assign b_limb     = b_q[j_q*LIMB_W +: LIMB_W];
	assign partial    = MAC_ACC_W'(prod_s1) << (sh_s1 * LIMB_W);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			i_q     <= '0;
			j_q     <= 1'b0;
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			vld_s1  <= run_q;
			last_s1 <= issue_last;
			done_q  <= vld_s1 && last_s1;
			if (cmd.start) begin
				run_q <= 1'b1;
				i_q   <= '0;
				j_q   <= 1'b0;
			end else if (run_q) begin
				if (issue_last)
					run_q <= 1'b0;
				if (j_q == b_last_q) begin
					j_q <= 1'b0;
					i_q <= i_q + 2'd1;
				end else begin
					j_q <= j_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			a_q      <= a;
			b_q      <= b;
			a_last_q <= cmd.a_last;
			b_last_q <= cmd.b_last;
		end
		if (run_q) begin
			prod_s1 <= a_limb * b_limb;
			sh_s1   <= i_q + {1'b0, j_q};
		end
		if (cmd.start)
			acc_q <= '0;
		else if (vld_s1)
			acc_q <= acc_q + partial;
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

/* hdl/windowed_stability_detector.sv */
// An add squares the new samples, and on a full window the evicted ones too, then updates the sums.
// A check on a filling window goes straight to its result; on a full window it uses the multiplier.
// Flow: one request at a time; the next can be taken once its predecessor's result is registered.
// All products come from the single 32x32 multiplier, one partial product a cycle.
// Reset: arst_n clears window state, sums, streak and output; registers take their defaults.
// The sample ring is never read before being rewritten and is not cleared.
// ----------------------------------------------------------------------------
// windowed_stability_detector: rolling-window variance convergence check
// Keeps running sums and sums of squares of two sample streams over a ring
// window and tests relative fluctuation with an exact cross-multiplied compare.
// ----------------------------------------------------------------------------
module windowed_stability_detector #(
	parameter int WINDOW_DEPTH = 512,
	parameter int SAMPLE_BITS  = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [wsd_pkg::IN_DATA_W-1:0]   s_tdata,   // lift_sample[31:0], drag_sample[63:32]
	input  logic                            s_tuser,   // action
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [wsd_pkg::OUT_DATA_W-1:0]  m_tdata,   // converged, window_full, pass_streak[9:2]
	input  logic                            cfg_we,
	input  logic [wsd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [wsd_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import wsd_pkg::*;

	localparam int AW    = $clog2(WINDOW_DEPTH);
	localparam int NW    = $clog2(WINDOW_DEPTH + 1);
	localparam int SUM_W = SAMPLE_BITS + AW;
	localparam int SQ_W  = 2 * SAMPLE_BITS - 16;
	localparam int SQS_W = SQ_W + AW;
	localparam int S2_W  = 2 * SUM_W;
	localparam int NQ_W  = SQS_W + NW;
	localparam int D_W   = NQ_W + 16;

	function automatic logic [SAMPLE_BITS-1:0] smag(input logic signed [SAMPLE_BITS-1:0] x);
		smag = x[SAMPLE_BITS-1] ? -x : x;
	endfunction

	wsd_state_t state_q, state_nx;

	logic                          issued_q;
	logic [TOL_W-1:0]              tol_q;
	logic [REQ_W-1:0]              req_q;
	logic [WLEN_W-1:0]             wlen_q;
	logic [AW-1:0]                 slot_q;
	logic [NW-1:0]                 fill_q;
	logic signed [SUM_W-1:0]       lsum_q, dsum_q;
	logic [SQS_W-1:0]              lsq_q, dsq_q;
	logic [REQ_W-1:0]              streak_q;
	logic                          sel_q;
	logic                          pass_q;
	logic                          conv_q;
	logic                          out_valid_q;
	logic [OUT_DATA_W-1:0]         out_data_q;
	logic signed [SAMPLE_BITS-1:0] lnew_q, dnew_q;
	logic [2*LIMB_W-1:0]           t2_q;
	logic [S2_W-1:0]               s2_q;
	logic [D_W-1:0]                d_q;
	logic [2*SAMPLE_BITS-1:0]      rd_q;
	logic [2*SAMPLE_BITS-1:0]      ring_mem [WINDOW_DEPTH];

	logic [NW-1:0]                 n;
	logic                          full;
	logic                          accept;
	logic [AW-1:0]                 slot_eff;
	logic [NW-1:0]                 slot_inc;
	logic [AW-1:0]                 slot_nx;
	logic signed [SAMPLE_BITS-1:0] lold, dold;
	logic signed [SUM_W-1:0]       lold_ext, dold_ext;
	logic signed [SUM_W-1:0]       ck_sum;
	logic [SQS_W-1:0]              ck_sq;
	logic [SUM_W-1:0]              abs_s;
	logic                          ck_zero;
	logic [SQS_W-1:0]              sq_new;
	logic [D_W-1:0]                nq16, s2x, d_nx;
	logic [MAC_ACC_W-1:0]          lhs_ts, lhs_tn;
	logic [REQ_W-1:0]              streak_nx, need;
	logic                          mem_we;

	mac_cmd_t                      mac_cmd;
	logic [MAC_A_W-1:0]            mac_a;
	logic [MAC_B_W-1:0]            mac_b;
	logic                          mac_done;
	logic [MAC_ACC_W-1:0]          mac_prod;
	logic                          op_state;

	wsd_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mac_cmd),
		.a      (mac_a),
		.b      (mac_b),
		.done   (mac_done),
		.prod   (mac_prod)
	);

	// effective window length, saturated to [2, WINDOW_DEPTH]
	always_comb begin
		if (wlen_q < WLEN_W'(2))
			n = NW'(2);
		else if (32'(wlen_q) > WINDOW_DEPTH)
			n = NW'(WINDOW_DEPTH);
		else
			n = NW'(wlen_q);
	end

	assign full     = fill_q >= n;
	assign accept   = s_tvalid && s_tready;
	assign slot_eff = (NW'(slot_q) >= n) ? '0 : slot_q;
	assign slot_inc = NW'(slot_eff) + NW'(1);
	assign slot_nx  = (slot_inc >= n) ? '0 : slot_inc[AW-1:0];

	assign lold     = rd_q[SAMPLE_BITS-1:0];
	assign dold     = rd_q[2*SAMPLE_BITS-1:SAMPLE_BITS];
	assign lold_ext = full ? SUM_W'(lold) : '0;
	assign dold_ext = full ? SUM_W'(dold) : '0;

	assign ck_sum  = sel_q ? dsum_q : lsum_q;
	assign ck_sq   = sel_q ? dsq_q : lsq_q;
	assign abs_s   = ck_sum[SUM_W-1] ? -ck_sum : ck_sum;
	assign ck_zero = (ck_sum == '0);

	// squares keep 32 fractional bits
	assign sq_new = SQS_W'(mac_prod[2*SAMPLE_BITS-1:16]);

	// D = max(0, n*Q*2^16 - S^2)
	assign nq16 = {mac_prod[NQ_W-1:0], 16'b0};
	assign s2x  = D_W'(s2_q);
	assign d_nx = (nq16 > s2x) ? (nq16 - s2x) : '0;

	assign lhs_ts = MAC_ACC_W'({d_q, 64'b0});
	assign lhs_tn = MAC_ACC_W'({ck_sq, 32'b0});

	assign need      = (req_q == '0) ? REQ_W'(1) : req_q;
	assign streak_nx = !pass_q ? '0 :
	                   (streak_q == STREAK_MAX) ? streak_q : streak_q + REQ_W'(1);

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					if (s_tuser == ACTION_ADD)
						state_nx = ST_SQ_LN;
					else if (!full)
						state_nx = ST_FINISH;
					else
						state_nx = ST_T2;
				end
			end
			ST_SQ_LN:   if (mac_done) state_nx = full ? ST_SQ_LO : ST_SQ_DN;
			ST_SQ_LO:   if (mac_done) state_nx = ST_SQ_DN;
			ST_SQ_DN:   if (mac_done) state_nx = full ? ST_SQ_DO : ST_ADD_UPD;
			ST_SQ_DO:   if (mac_done) state_nx = ST_ADD_UPD;
			ST_ADD_UPD: state_nx = ST_FINISH;
			ST_T2:      if (mac_done) state_nx = ST_SIG;
			ST_SIG:     state_nx = ck_zero ? ST_TN : ST_S2;
			ST_S2:      if (mac_done) state_nx = ST_NQ;
			ST_NQ:      if (mac_done) state_nx = ST_TS;
			ST_TS:      if (mac_done) state_nx = sel_q ? ST_STREAK : ST_SIG;
			ST_TN:      if (mac_done) state_nx = sel_q ? ST_STREAK : ST_SIG;
			ST_STREAK:  state_nx = ST_FINISH;
			ST_FINISH:  if (!out_valid_q || m_tready) state_nx = ST_IDLE;
			default:    state_nx = ST_IDLE;
		endcase
	end

	// outputs: handshake and multiplier operands
	always_comb begin
		s_tready = (state_q == ST_IDLE);
		mem_we   = (state_q == ST_ADD_UPD);
		op_state = 1'b1;
		mac_cmd  = '0;
		mac_a    = '0;
		mac_b    = '0;
		case (state_q)
			ST_SQ_LN: begin
				mac_a = MAC_A_W'(smag(lnew_q));
				mac_b = MAC_B_W'(smag(lnew_q));
			end
			ST_SQ_LO: begin
				mac_a = MAC_A_W'(smag(lold));
				mac_b = MAC_B_W'(smag(lold));
			end
			ST_SQ_DN: begin
				mac_a = MAC_A_W'(smag(dnew_q));
				mac_b = MAC_B_W'(smag(dnew_q));
			end
			ST_SQ_DO: begin
				mac_a = MAC_A_W'(smag(dold));
				mac_b = MAC_B_W'(smag(dold));
			end
			ST_T2: begin
				mac_a = MAC_A_W'(tol_q);
				mac_b = MAC_B_W'(tol_q);
			end
			ST_S2: begin
				mac_a          = MAC_A_W'(abs_s);
				mac_b          = MAC_B_W'(abs_s);
				mac_cmd.a_last = 2'd1;
				mac_cmd.b_last = 1'b1;
			end
			ST_NQ: begin
				mac_a          = MAC_A_W'(ck_sq);
				mac_b          = MAC_B_W'(n);
				mac_cmd.a_last = 2'd1;
			end
			ST_TS: begin
				mac_a          = MAC_A_W'(s2_q);
				mac_b          = t2_q;
				mac_cmd.a_last = 2'd2;
				mac_cmd.b_last = 1'b1;
			end
			ST_TN: begin
				mac_a          = MAC_A_W'(t2_q);
				mac_b          = MAC_B_W'(n);
				mac_cmd.a_last = 2'd1;
			end
			default: op_state = 1'b0;
		endcase
		mac_cmd.start = op_state && !issued_q;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// control and window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			issued_q    <= 1'b0;
			tol_q       <= TOL_RESET;
			req_q       <= REQ_RESET;
			wlen_q      <= WLEN_RESET;
			slot_q      <= '0;
			fill_q      <= '0;
			lsum_q      <= '0;
			dsum_q      <= '0;
			lsq_q       <= '0;
			dsq_q       <= '0;
			streak_q    <= '0;
			sel_q       <= 1'b0;
			pass_q      <= 1'b0;
			conv_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;

			if (mac_cmd.start)
				issued_q <= 1'b1;
			else if (mac_done)
				issued_q <= 1'b0;

			if (cfg_we) begin
				case (cfg_index)
					REG_TOLERANCE: tol_q <= cfg_data[TOL_W-1:0];
					REG_REQUIRED:  req_q <= cfg_data[REQ_W-1:0];
					REG_WINDOW: begin
						wlen_q <= cfg_data[WLEN_W-1:0];
						slot_q <= '0;
						fill_q <= '0;
						lsum_q <= '0;
						dsum_q <= '0;
						lsq_q  <= '0;
						dsq_q  <= '0;
					end
					default: ;
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						sel_q  <= 1'b0;
						pass_q <= 1'b1;
						conv_q <= 1'b0;
						if (s_tuser == ACTION_CHECK && !full)
							streak_q <= '0;
					end
				end
				ST_SQ_LN: if (mac_done) lsq_q <= lsq_q + sq_new;
				ST_SQ_LO: if (mac_done) lsq_q <= lsq_q - sq_new;
				ST_SQ_DN: if (mac_done) dsq_q <= dsq_q + sq_new;
				ST_SQ_DO: if (mac_done) dsq_q <= dsq_q - sq_new;
				ST_ADD_UPD: begin
					lsum_q <= lsum_q + SUM_W'(lnew_q) - lold_ext;
					dsum_q <= dsum_q + SUM_W'(dnew_q) - dold_ext;
					if (!full)
						fill_q <= fill_q + NW'(1);
					slot_q <= slot_nx;
				end
				ST_TS: begin
					if (mac_done) begin
						pass_q <= pass_q && (lhs_ts < mac_prod);
						sel_q  <= 1'b1;
					end
				end
				ST_TN: begin
					if (mac_done) begin
						pass_q <= pass_q && (lhs_tn < mac_prod);
						sel_q  <= 1'b1;
					end
				end
				ST_STREAK: begin
					streak_q <= streak_nx;
					conv_q   <= (streak_nx >= need);
				end
				default: ;
			endcase

			if (state_q == ST_FINISH && (!out_valid_q || m_tready))
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	// data path registers
	always_ff @(posedge clk) begin
		if (accept) begin
			lnew_q <= s_tdata[SAMPLE_BITS-1:0];
			dnew_q <= s_tdata[SAMPLE_FIELD_W +: SAMPLE_BITS];
		end
		if (state_q == ST_T2 && mac_done)
			t2_q <= mac_prod[2*LIMB_W-1:0];
		if (state_q == ST_S2 && mac_done)
			s2_q <= mac_prod[S2_W-1:0];
		if (state_q == ST_NQ && mac_done)
			d_q <= d_nx;
		if (state_q == ST_FINISH && (!out_valid_q || m_tready))
			out_data_q <= {(OUT_DATA_W - REQ_W - 2)'(0), streak_q, full, conv_q};
	end

	// sample ring, lift in the low half
	always_ff @(posedge clk) begin
		if (mem_we)
			ring_mem[slot_eff] <= {dnew_q, lnew_q};
		rd_q <= ring_mem[slot_eff];
	end

endmodule

/* hdl/wsd_checker.sv */
// ----------------------------------------------------------------------------
// wsd_checker: port-level checks of the windowed stability detector
// Watches the stream ports and the result fields over time.
// ----------------------------------------------------------------------------
module wsd_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [wsd_pkg::OUT_DATA_W-1:0] m_tdata
);
	import wsd_pkg::*;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// converged only on a full window
	a_conv_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[1])
		else $error("converged without full window");

	// converged needs at least one pass in the streak
	a_conv_streak: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[9:2] != 8'd0)
		else $error("converged with empty streak");

	// one request at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while busy");

endmodule

bind windowed_stability_detector wsd_checker u_wsd_checker (.*);

/* tb/wsd_checker.sv */
// ----------------------------------------------------------------------------
// wsd_scoreboard: response predictor and comparator for the stability detector
// Watches the request, result and register channels, keeps its own copy of
// the two sample windows, sums and streak, and compares each result with the
// oldest outstanding prediction.
// ----------------------------------------------------------------------------
module wsd_scoreboard #(
	parameter int WINDOW_DEPTH = 512
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [wsd_pkg::IN_DATA_W-1:0]   s_tdata,   // lift_sample[31:0], drag_sample[63:32]
	input  logic                            s_tuser,   // action
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [wsd_pkg::OUT_DATA_W-1:0]  m_tdata,   // converged, window_full, pass_streak[9:2]
	input  logic                            cfg_we,
	input  logic [wsd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [wsd_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int                              error_count,
	output int                              open_requests,
	output int                              converged_count,
	output int                              peak_streak
);
	import wsd_pkg::*;

	// the block holds one request at a time; a few slots leave room to flag extras
	localparam int AWAIT_DEPTH = 4;

	// packed so that converged lands in bit 0, as on the result bus
	typedef struct packed {
		logic [7:0] streak;
		logic       window_full;
		logic       converged;
	} verdict_t;

	logic signed [31:0] lift_hist [WINDOW_DEPTH];
	logic signed [31:0] drag_hist [WINDOW_DEPTH];
	int unsigned        slot_ptr;
	int unsigned        filled;
	longint             lift_acc;
	longint             drag_acc;
	logic [63:0]        lift_sq_acc;
	logic [63:0]        drag_sq_acc;
	logic [7:0]         streak;
	logic [TOL_W-1:0]   tol_r;
	logic [REQ_W-1:0]   need_r;
	logic [WLEN_W-1:0]  wlen_r;
	verdict_t           awaited_verdicts [AWAIT_DEPTH];
	logic [1:0]         await_head;
	int unsigned        await_count;

	function automatic void clear_window();
		slot_ptr    = 0;
		filled      = 0;
		lift_acc    = 0;
		drag_acc    = 0;
		lift_sq_acc = '0;
		drag_sq_acc = '0;
	endfunction

	function automatic void store_verdict(verdict_t v);
		awaited_verdicts[await_head + 2'(await_count)] = v;
		await_count++;
	endfunction

	function automatic verdict_t take_oldest_verdict();
		verdict_t v;
		v = awaited_verdicts[await_head];
		await_head = await_head + 2'd1;
		await_count--;
		return v;
	endfunction

	// exact square in Q16.48, floored to 32 fractional bits
	function automatic logic [63:0] square_frac32(logic signed [31:0] v);
		logic [63:0] mag;
		mag = v[31] ? 64'd0 - {{32{1'b1}}, v} : {32'd0, v};
		return (mag * mag) >> 16;
	endfunction

	function automatic int unsigned span_of(logic [WLEN_W-1:0] w);
		if (w < 2) return 2;
		if (w > WINDOW_DEPTH) return WINDOW_DEPTH;
		return int'(w);
	endfunction

	// D = max(0, n*Q*2^16 - S^2) against T^2*S^2 (or T^2*n^2 at zero mean)
	function automatic logic fluctuation_ok(longint sum, logic [63:0] sq, int unsigned n);
		logic [63:0]  mag;
		logic [63:0]  t2;
		logic [191:0] n_w, s2, nq, dev, lhs, rhs;
		mag = (sum < 0) ? 64'd0 - 64'(sum) : 64'(sum);
		t2  = {32'd0, tol_r} * {32'd0, tol_r};
		n_w = 192'(n);
		s2  = {128'd0, mag} * {128'd0, mag};
		nq  = ({128'd0, sq} * n_w) << 16;
		dev = (nq > s2) ? nq - s2 : '0;
		if (mag != 0) begin
			lhs = dev << 64;
			rhs = s2 * {128'd0, t2};
		end else begin
			lhs = dev << 16;
			rhs = {128'd0, t2} * n_w * n_w;
		end
		return lhs < rhs;
	endfunction

	function automatic verdict_t predict_window_verdict(logic act, logic signed [31:0] lv,
			logic signed [31:0] dv);
		int unsigned n;
		int unsigned need;
		logic        pass;
		verdict_t    v;
		n = span_of(wlen_r);
		v = '0;
		if (slot_ptr >= n) slot_ptr = 0;
		if (act == ACTION_ADD) begin
			if (filled >= n) begin
				lift_acc    -= lift_hist[slot_ptr];
				drag_acc    -= drag_hist[slot_ptr];
				lift_sq_acc -= square_frac32(lift_hist[slot_ptr]);
				drag_sq_acc -= square_frac32(drag_hist[slot_ptr]);
			end else begin
				filled++;
			end
			lift_hist[slot_ptr] = lv;
			drag_hist[slot_ptr] = dv;
			lift_acc    += lv;
			drag_acc    += dv;
			lift_sq_acc += square_frac32(lv);
			drag_sq_acc += square_frac32(dv);
			slot_ptr = (slot_ptr + 1 >= n) ? 0 : slot_ptr + 1;
		end else if (filled < n) begin
			streak = '0;
		end else begin
			need = (need_r == 0) ? 1 : int'(need_r);
			pass = fluctuation_ok(lift_acc, lift_sq_acc, n);
			pass = fluctuation_ok(drag_acc, drag_sq_acc, n) & pass;
			if (pass) begin
				if (streak != STREAK_MAX) streak++;
			end else begin
				streak = '0;
			end
			v.converged = (streak >= need);
		end
		v.window_full = (filled >= n);
		v.streak      = streak;
		return v;
	endfunction

	task automatic report_mismatch(string what);
		error_count++;
		if (error_count <= 200) $display("[%0t] mismatch: %s", $time, what);
	endtask

	always @(posedge clk or negedge arst_n) begin
		verdict_t got;
		verdict_t want;
		if (!arst_n) begin
			tol_r  = TOL_RESET;
			need_r = REQ_RESET;
			wlen_r = WLEN_RESET;
			streak = '0;
			clear_window();
			await_head      = '0;
			await_count     = 0;
			error_count     = 0;
			converged_count = 0;
			peak_streak     = 0;
			open_requests <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_TOLERANCE: tol_r = cfg_data[TOL_W-1:0];
					REG_REQUIRED:  need_r = cfg_data[REQ_W-1:0];
					REG_WINDOW: begin
						wlen_r = cfg_data[WLEN_W-1:0];
						clear_window();
					end
					default: ;
				endcase
			end
			// results first: a result never belongs to the request taken in the same cycle
			if (m_tvalid && m_tready) begin
				got = verdict_t'(m_tdata[9:0]);
				if (await_count == 0) begin
					report_mismatch($sformatf("unexpected result %h", m_tdata));
				end else begin
					want = take_oldest_verdict();
					if (got.converged !== want.converged)
						report_mismatch($sformatf("converged %b, predicted %b",
							got.converged, want.converged));
					if (got.window_full !== want.window_full)
						report_mismatch($sformatf("window_full %b, predicted %b",
							got.window_full, want.window_full));
					if (got.streak !== want.streak)
						report_mismatch($sformatf("pass_streak %0d, predicted %0d",
							got.streak, want.streak));
				end
			end
			if (s_tvalid && s_tready) begin
				want = predict_window_verdict(s_tuser, s_tdata[31:0], s_tdata[63:32]);
				if (want.converged) converged_count++;
				if (int'(want.streak) > peak_streak) peak_streak = int'(want.streak);
				if (await_count == AWAIT_DEPTH)
					report_mismatch("too many requests taken without a result");
				else
					store_verdict(want);
			end
			open_requests <= int'(await_count);
		end
	end

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the windowed stability detector
// Directed requests at field extremes and corner settings, then random phases
// of near-steady sample streams with noise, a saturating streak run and a full
// 512-entry window, under bursty input and a stalling result channel.
// ----------------------------------------------------------------------------
module testbench;
	import wsd_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;   // lift_sample[31:0], drag_sample[63:32]
	logic                  s_tuser   = 1'b0; // action
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;          // converged, window_full, pass_streak[9:2]
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	int mismatches;
	int outstanding;
	int converged_hits;
	int peak_streak;

	int burst_left   = 0;
	int sent         = 0;
	int checks_sent  = 0;
	int writes_done  = 0;
	bit hold_request = 1'b0;
	bit held_off     = 1'b0;

	windowed_stability_detector dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	wsd_scoreboard wsd_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.error_count     (mismatches),
		.open_requests   (outstanding),
		.converged_count (converged_hits),
		.peak_streak     (peak_streak)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("timeout: requests or results stopped moving");
		$display("Regression FAIL");
		$finish;
	end

	task automatic pause_sender(int cycles);
		s_tvalid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// one request, with burst/gap pacing; valid stays high inside a burst
	task automatic offer(logic act, logic [31:0] lv, logic [31:0] dv);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 9) == 0) ? int'($urandom_range(30, 80))
				: int'($urandom_range(1, 10));
			gap = int'($urandom_range(0, 6));
			if (gap != 0) pause_sender(gap);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= {dv, lv};
		s_tuser  <= act;
		do @(posedge clk); while (!s_tready);
		sent++;
		if (act == ACTION_CHECK) checks_sent++;
	endtask

	// registers only change with the block idle and nothing outstanding
	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		pause_sender(1);
		while (outstanding != 0) @(posedge clk);
		repeat (3) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		writes_done++;
		burst_left = 0;
	endtask

	task automatic configure(logic [31:0] tol, logic [7:0] req, logic [9:0] wlen,
			bit write_window);
		write_register(REG_TOLERANCE, tol);
		write_register(REG_REQUIRED, ($urandom & 32'hFFFF_FF00) | req);
		if (write_window) write_register(REG_WINDOW, ($urandom & ~32'h3FF) | wlen);
	endtask

	// steady levels plus noise of random width; some phases alternate sign for zero mean
	task automatic run_random_phase(int count);
		logic [31:0] lift_base, drag_base, lv, dv, tol;
		logic [7:0]  req;
		logic [9:0]  wlen;
		int          lift_bits, drag_bits, check_pct, style;
		bit          toggle;
		case ($urandom_range(0, 5))
			0:       tol = '0;
			1:       tol = '1;
			default: tol = $urandom >> $urandom_range(0, 31);
		endcase
		case ($urandom_range(0, 7))
			0:       req = 8'd255;
			1:       req = 8'($urandom_range(0, 255));
			default: req = 8'($urandom_range(0, 6));
		endcase
		case ($urandom_range(0, 9))
			0:       wlen = 10'($urandom_range(0, 1));
			1:       wlen = 10'($urandom_range(13, 40));
			default: wlen = 10'($urandom_range(2, 12));
		endcase
		configure(tol, req, wlen, $urandom_range(0, 9) < 7);
		lift_base = $signed($urandom) >>> $urandom_range(0, 24);
		drag_base = $signed($urandom) >>> $urandom_range(0, 24);
		lift_bits = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 31))
			: int'($urandom_range(0, 12));
		drag_bits = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 31))
			: int'($urandom_range(0, 12));
		check_pct = int'($urandom_range(10, 45));
		style     = int'($urandom_range(0, 5));
		toggle    = 1'b0;
		repeat (count) begin
			if ($urandom_range(0, 99) < check_pct) begin
				offer(ACTION_CHECK, $urandom, $urandom);
			end else begin
				lv = lift_base + ($urandom & ((32'd1 << lift_bits) - 32'd1))
					- ((32'd1 << lift_bits) >> 1);
				dv = drag_base + ($urandom & ((32'd1 << drag_bits) - 32'd1))
					- ((32'd1 << drag_bits) >> 1);
				if (style == 0) begin
					lv = toggle ? lift_base : -lift_base;
					dv = toggle ? drag_base : -drag_base;
					toggle = ~toggle;
				end
				if ($urandom_range(0, 9) == 0) begin
					lv = $urandom;
					dv = $urandom;
				end
				offer(ACTION_ADD, lv, dv);
			end
		end
	endtask

	// result side: stall patterns of random kind and length, one long hold-off
	initial begin
		int mode, span, step;
		forever begin
			mode = int'($urandom_range(0, 3));
			span = int'($urandom_range(16, 160));
			for (step = 0; step < span; step++) begin
				@(posedge clk);
				if (hold_request && !held_off) begin
					held_off = 1'b1;
					m_tready <= 1'b0;
					repeat (400) @(posedge clk);
				end
				case (mode)
					0:       m_tready <= 1'b1;
					1:       m_tready <= 1'($urandom_range(0, 1));
					2:       m_tready <= ($urandom_range(0, 7) == 0);
					default: m_tready <= (step % 4 != 3);
				endcase
			end
		end
	end

	initial begin
		int          phase, general_items, n, i, settle;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: 500-sample window, still filling
		offer(ACTION_CHECK, '1, '1);
		offer(ACTION_ADD, 32'h7FFF_FFFF, 32'h8000_0000);
		offer(ACTION_CHECK, '0, '0);

		// window length 0 acts as 2, required count 0 acts as 1, full tolerance
		configure(32'hFFFF_FFFF, 8'd0, 10'd0, 1'b1);
		offer(ACTION_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		offer(ACTION_CHECK, $urandom, $urandom);
		offer(ACTION_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		offer(ACTION_CHECK, $urandom, $urandom);
		offer(ACTION_ADD, 32'h8000_0000, 32'h8000_0000);
		offer(ACTION_CHECK, $urandom, $urandom);   // max beside min: wide spread
		offer(ACTION_ADD, 32'h8000_0000, 32'h8000_0000);
		offer(ACTION_CHECK, $urandom, $urandom);
		offer(ACTION_ADD, '0, '0);
		offer(ACTION_ADD, '0, '0);
		offer(ACTION_CHECK, $urandom, $urandom);   // zero mean, no spread

		// zero tolerance never passes, zero mean with spread
		write_register(REG_TOLERANCE, '0);
		offer(ACTION_CHECK, $urandom, $urandom);
		offer(ACTION_ADD, 32'h0000_0001, 32'hFFFF_FFFF);
		offer(ACTION_ADD, 32'hFFFF_FFFF, 32'h0000_0001);
		offer(ACTION_CHECK, $urandom, $urandom);

		// unused index must change nothing; window length 1 acts as 2
		write_register(REG_UNUSED, $urandom);
		configure(32'h1000_0000, 8'd2, 10'd1, 1'b1);
		offer(ACTION_ADD, 32'h0123_4567, 32'hFEDC_BA98);
		offer(ACTION_ADD, 32'h0123_4567, 32'hFEDC_BA98);
		offer(ACTION_CHECK, $urandom, $urandom);
		offer(ACTION_CHECK, $urandom, $urandom);
		offer(ACTION_CHECK, $urandom, $urandom);

		phase = 0;
		general_items = 0;
		while (phase < 2 || general_items < 40) begin
			phase++;
			if (phase == 2) begin
				// length above the depth saturates to 512; extreme samples fill the sums.
				// The constant window then passes every check, so the streak runs into
				// saturation while the result side holds off and requests back up.
				configure($urandom | 32'd1, 8'd255, 10'd1023, 1'b1);
				for (i = 0; i < 512; i++) begin
					if (i % 128 == 0) offer(ACTION_CHECK, $urandom, $urandom);
					offer(ACTION_ADD, 32'h8000_0000, 32'h7FFF_FFFF);
				end
				hold_request = 1'b1;
				repeat (258) offer(ACTION_CHECK, $urandom, $urandom);
				for (i = 0; i < 8; i++) begin
					offer(ACTION_ADD, $urandom, $urandom);
					if (i % 2 == 1) offer(ACTION_CHECK, $urandom, $urandom);
				end
			end else begin
				n = int'($urandom_range(15, 60));
				run_random_phase(n);
				general_items += n;
			end
		end

		pause_sender(1);
		settle = 0;
		while (outstanding != 0 && settle < 20000) begin
			@(posedge clk);
			settle++;
		end
		repeat (60) @(posedge clk);

		$display("Ran %0d requests (%0d checks) over %0d register writes;", sent, checks_sent,
			writes_done);
		$display("%0d converged results, highest streak %0d, %0d mismatches.", converged_hits,
			peak_streak, mismatches);
		if (mismatches == 0 && outstanding == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

/* windowed_stability_detector.f */
hdl/wsd_pkg.sv
hdl/wsd_mac.sv
hdl/windowed_stability_detector.sv
hdl/wsd_checker.sv
tb/wsd_checker.sv
tb/testbench.sv
